/* rtl/spwr_pkg.sv */
// Shared types, constants and the control store of the pixel write replicator.
`default_nettype none

package spwr_pkg;

  localparam int SCREEN_WIDTH  = 1024;
  localparam int SCREEN_HEIGHT = 1024;
  localparam int MAX_WRITES    = 64;
  localparam int STRIPE_STEP   = 8;

  localparam int CW       = 10;
  localparam int COLW     = 8;
  localparam int MODEW    = 4;
  localparam int CFG_IDXW = 3;
  localparam int CFG_DW   = 10;
  localparam int PCW      = 6;
  localparam int CNTW     = $clog2(MAX_WRITES + 1);
  localparam int CMPW     = 14;
  localparam int C1W      = 10;
  localparam int DIVW     = 11;
  localparam int REM_BITS = 10;
  localparam int REM_CNTW = $clog2(REM_BITS);

  typedef enum logic [CFG_IDXW-1:0] {
    REG_MODE      = 3'd0,
    REG_X_START   = 3'd1,
    REG_X_STOP    = 3'd2,
    REG_Y_START   = 3'd3,
    REG_Y_STOP    = 3'd4,
    REG_ROW_LIMIT = 3'd5,
    REG_DEGREE    = 3'd6,
    REG_PI_PERIOD = 3'd7
  } cfg_reg_e;

  typedef enum logic [MODEW-1:0] {
    MODE_NONE        = 4'd0,
    MODE_X           = 4'd1,
    MODE_Y           = 4'd2,
    MODE_ORIGIN      = 4'd3,
    MODE_BOTH        = 4'd4,
    MODE_BASIN_X     = 4'd5,
    MODE_BASIN_XS    = 4'd6,
    MODE_BASIN_BOTH  = 4'd7,
    MODE_BASIN_BOTHS = 4'd8,
    MODE_PI          = 4'd9,
    MODE_PI_ORIGIN   = 4'd10,
    MODE_PI_BOTH     = 4'd11
  } mode_e;

  typedef enum logic [2:0] {
    OP_END  = 3'd0,
    OP_EMIT = 3'd1,
    OP_JMP  = 3'd2,
    OP_REM  = 3'd3,
    OP_ADV  = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    C_ALW   = 3'd0,
    C_ROW   = 3'd1,
    C_COL   = 3'd2,
    C_RC    = 3'd3,
    C_CZERO = 3'd4,
    C_NGO   = 3'd5,
    C_PZ    = 3'd6
  } cond_e;

  typedef enum logic {XS_X = 1'b0, XS_J = 1'b1} xsel_e;
  typedef enum logic {YS_Y = 1'b0, YS_I = 1'b1} ysel_e;
  typedef enum logic {RS_C = 1'b0, RS_C1 = 1'b1} rsel_e;

  typedef enum logic [1:0] {
    CS_COLOR = 2'd0,
    CS_C1S   = 2'd1,
    CS_R0    = 2'd2,
    CS_R1    = 2'd3
  } csel_e;

  typedef struct packed {
    op_e             op;
    cond_e           cond;
    xsel_e           xs;
    ysel_e           ys;
    csel_e           cs;
    rsel_e           rs;
    logic [PCW-1:0]  tgt;
  } ctrl_t;

  typedef struct packed {
    logic             start;
    logic [DIVW-1:0]  dividend;
    logic [COLW-1:0]  divisor;
  } rem_req_t;

  typedef struct packed {
    logic             done;
    logic [COLW-1:0]  rem;
  } rem_rsp_t;

  localparam logic [PCW-1:0] PC_END  = 6'd0;
  localparam logic [PCW-1:0] PC_X    = 6'd1;
  localparam logic [PCW-1:0] PC_Y    = 6'd4;
  localparam logic [PCW-1:0] PC_O    = 6'd7;
  localparam logic [PCW-1:0] PC_F    = 6'd10;
  localparam logic [PCW-1:0] PC_B2   = 6'd15;
  localparam logic [PCW-1:0] PC_B4   = 6'd19;
  localparam logic [PCW-1:0] PC_PI   = 6'd27;
  localparam logic [PCW-1:0] PC_PIO  = 6'd31;
  localparam logic [PCW-1:0] PC_PIB  = 6'd36;

  function automatic ctrl_t cw_end();
    cw_end = '{op: OP_END, cond: C_ALW, xs: XS_X, ys: YS_Y, cs: CS_COLOR, rs: RS_C,
               tgt: PC_END};
  endfunction

  function automatic ctrl_t cw_emit(xsel_e x, ysel_e y, csel_e c, cond_e k);
    cw_emit = '{op: OP_EMIT, cond: k, xs: x, ys: y, cs: c, rs: RS_C, tgt: PC_END};
  endfunction

  function automatic ctrl_t cw_jmp(cond_e k, logic [PCW-1:0] t);
    cw_jmp = '{op: OP_JMP, cond: k, xs: XS_X, ys: YS_Y, cs: CS_COLOR, rs: RS_C, tgt: t};
  endfunction

  function automatic ctrl_t cw_rem(rsel_e r);
    cw_rem = '{op: OP_REM, cond: C_ALW, xs: XS_X, ys: YS_Y, cs: CS_COLOR, rs: r,
               tgt: PC_END};
  endfunction

  function automatic ctrl_t cw_adv(logic [PCW-1:0] t);
    cw_adv = '{op: OP_ADV, cond: C_ALW, xs: XS_X, ys: YS_Y, cs: CS_COLOR, rs: RS_C, tgt: t};
  endfunction

  function automatic logic [PCW-1:0] entry(logic [MODEW-1:0] mode);
    case (mode)
      MODE_X:           entry = PC_X;
      MODE_Y:           entry = PC_Y;
      MODE_ORIGIN:      entry = PC_O;
      MODE_BOTH:        entry = PC_F;
      MODE_BASIN_X:     entry = PC_B2;
      MODE_BASIN_XS:    entry = PC_B2;
      MODE_BASIN_BOTH:  entry = PC_B4;
      MODE_BASIN_BOTHS: entry = PC_B4;
      MODE_PI:          entry = PC_PI;
      MODE_PI_ORIGIN:   entry = PC_PIO;
      MODE_PI_BOTH:     entry = PC_PIB;
      default:          entry = PC_END;
    endcase
  endfunction

  function automatic ctrl_t ucode(logic [PCW-1:0] pc);
    case (pc)
      PC_X:            ucode = cw_emit(XS_X, YS_Y, CS_COLOR, C_ALW);
      PC_X + 6'd1:     ucode = cw_emit(XS_X, YS_I, CS_COLOR, C_ROW);
      PC_Y:            ucode = cw_emit(XS_X, YS_Y, CS_COLOR, C_ALW);
      PC_Y + 6'd1:     ucode = cw_emit(XS_J, YS_Y, CS_COLOR, C_COL);
      PC_O:            ucode = cw_emit(XS_X, YS_Y, CS_COLOR, C_ALW);
      PC_O + 6'd1:     ucode = cw_emit(XS_J, YS_I, CS_COLOR, C_RC);
      PC_F:            ucode = cw_emit(XS_X, YS_Y, CS_COLOR, C_ALW);
      PC_F + 6'd1:     ucode = cw_emit(XS_J, YS_Y, CS_COLOR, C_COL);
      PC_F + 6'd2:     ucode = cw_emit(XS_X, YS_I, CS_COLOR, C_ROW);
      PC_F + 6'd3:     ucode = cw_emit(XS_J, YS_I, CS_COLOR, C_RC);
      PC_B2:           ucode = cw_rem(RS_C);
      PC_B2 + 6'd1:    ucode = cw_emit(XS_X, YS_Y, CS_COLOR, C_ALW);
      PC_B2 + 6'd2:    ucode = cw_emit(XS_X, YS_I, CS_R0, C_ROW);
      PC_B4:           ucode = cw_jmp(C_CZERO, PC_F);
      PC_B4 + 6'd1:    ucode = cw_rem(RS_C);
      PC_B4 + 6'd2:    ucode = cw_rem(RS_C1);
      PC_B4 + 6'd3:    ucode = cw_emit(XS_X, YS_Y, CS_COLOR, C_ALW);
      PC_B4 + 6'd4:    ucode = cw_emit(XS_J, YS_Y, CS_C1S, C_COL);
      PC_B4 + 6'd5:    ucode = cw_emit(XS_X, YS_I, CS_R0, C_ROW);
      PC_B4 + 6'd6:    ucode = cw_emit(XS_J, YS_I, CS_R1, C_RC);
      PC_PI:           ucode = cw_jmp(C_NGO, PC_END);
      PC_PI + 6'd1:    ucode = cw_emit(XS_X, YS_Y, CS_COLOR, C_ALW);
      PC_PI + 6'd2:    ucode = cw_jmp(C_PZ, PC_END);
      PC_PI + 6'd3:    ucode = cw_adv(PC_PI);
      PC_PIO:          ucode = cw_jmp(C_NGO, PC_END);
      PC_PIO + 6'd1:   ucode = cw_emit(XS_X, YS_Y, CS_COLOR, C_ALW);
      PC_PIO + 6'd2:   ucode = cw_emit(XS_J, YS_I, CS_COLOR, C_RC);
      PC_PIO + 6'd3:   ucode = cw_jmp(C_PZ, PC_END);
      PC_PIO + 6'd4:   ucode = cw_adv(PC_PIO);
      PC_PIB:          ucode = cw_jmp(C_NGO, PC_END);
      PC_PIB + 6'd1:   ucode = cw_emit(XS_X, YS_Y, CS_COLOR, C_ALW);
      PC_PIB + 6'd2:   ucode = cw_emit(XS_J, YS_Y, CS_COLOR, C_COL);
      PC_PIB + 6'd3:   ucode = cw_emit(XS_X, YS_I, CS_COLOR, C_ROW);
      PC_PIB + 6'd4:   ucode = cw_emit(XS_J, YS_I, CS_COLOR, C_RC);
      PC_PIB + 6'd5:   ucode = cw_jmp(C_PZ, PC_END);
      PC_PIB + 6'd6:   ucode = cw_adv(PC_PIB);
      default:         ucode = cw_end();
    endcase
  endfunction

endpackage

`default_nettype wire

/* rtl/spwr_rem.sv */
// Bit-serial truncating remainder unit used for the basin colour remap.
`default_nettype none

module spwr_rem (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  spwr_pkg::rem_req_t req_i,
  output spwr_pkg::rem_rsp_t rsp_o
);
  import spwr_pkg::*;

  logic                busy_q, done_q, neg_q;
  logic [REM_CNTW-1:0] cnt_q;
  logic [REM_BITS-1:0] mag_q;
  logic [COLW-1:0]     rem_q, d_q;
  logic [DIVW-1:0]     abs_val;
  logic [COLW:0]       trial, diff;
  logic                ge;

  assign abs_val = req_i.dividend[DIVW-1] ? (DIVW'(0) - req_i.dividend) : req_i.dividend;
  assign trial   = {rem_q, mag_q[REM_BITS-1]};
  assign ge      = trial >= {1'b0, d_q};
  assign diff    = trial - {1'b0, d_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
      end else if (busy_q && (cnt_q == REM_CNTW'(REM_BITS - 1))) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      mag_q <= abs_val[REM_BITS-1:0];
      neg_q <= req_i.dividend[DIVW-1];
      d_q   <= req_i.divisor;
      rem_q <= '0;
      cnt_q <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? diff[COLW-1:0] : trial[COLW-1:0];
      mag_q <= {mag_q[REM_BITS-2:0], 1'b0};
      cnt_q <= cnt_q + REM_CNTW'(1);
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.rem  = neg_q ? (COLW'(0) - rem_q) : rem_q;

  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q)
    else $error("remainder unit restarted while running");

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("remainder done held for more than one cycle");

  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (rem_q < d_q))
    else $error("remainder not below divisor");

endmodule

`default_nettype wire

/* rtl/symmetric_pixel_write_replicator_core.sv */
// Top level of the symmetric pixel write replicator: registers, sequencer and datapath.
//
// A pixel is taken when start is high and busy is low; busy then stays high until
// every write it implies has been produced. Writes appear on wr_x_o, wr_y_o and
// wr_color_o for one cycle each with valid_o, the final one marked by last_o, and
// the receiver must take them as they come. A microcode sequencer steps one control
// word per cycle, but a remainder step holds the sequencer until the bit-serial
// remainder unit reports done. The basin modes run that unit once per colour remap:
// once in the two-way basin modes and twice in the four-way basin modes with a
// non-zero colour. Configuration writes are always taken: cfg_ready_o is tied high.
`default_nettype none

module symmetric_pixel_write_replicator_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [spwr_pkg::CW-1:0]       pix_x_i,
  input  logic [spwr_pkg::CW-1:0]       pix_y_i,
  input  logic [spwr_pkg::COLW-1:0]     pix_color_i,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [spwr_pkg::CFG_IDXW-1:0] cfg_index_i,
  input  logic [spwr_pkg::CFG_DW-1:0]   cfg_data_i,
  output logic                          valid_o,
  output logic [spwr_pkg::CW-1:0]       wr_x_o,
  output logic [spwr_pkg::CW-1:0]       wr_y_o,
  output logic [spwr_pkg::COLW-1:0]     wr_color_o,
  output logic                          last_o
);
  import spwr_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_e;

  localparam logic signed [CMPW-1:0] SCR_W = CMPW'(SCREEN_WIDTH);
  localparam logic signed [CMPW-1:0] SCR_H = CMPW'(SCREEN_HEIGHT);
  localparam logic [CNTW-1:0]        MAX_CNT = CNTW'(MAX_WRITES);
  localparam logic [COLW-1:0]        STRIPE = COLW'(STRIPE_STEP);

  logic [MODEW-1:0] mode_q;
  logic [CW-1:0]    xs_q, xe_q, ys_q, ye_q, crl_q, per_q;
  logic [COLW-1:0]  deg_q;

  state_e           state_q;
  logic [PCW-1:0]   pc_q;
  logic [CNTW-1:0]  cnt_q;
  logic             rem_run_q, pend_v_q, valid_q;
  logic [CW:0]      x_q;
  logic [CW-1:0]    y_q, pend_x_q, pend_y_q, out_x_q, out_y_q;
  logic [COLW-1:0]  color_q, r0_q, r1_q, pend_c_q, out_c_q;
  logic             last_q;

  ctrl_t            w;
  rem_req_t         rem_req;
  rem_rsp_t         rem_rsp;

  logic             run, accept, cond_ok, emit_go, flush, rem_done;
  logic             striped, row_ok, col_ok, pi_go;
  logic [COLW-1:0]  deg, s, c, c1s, remap_col, new_c;
  logic [C1W-1:0]   hp2, c1_u;
  logic signed [C1W-1:0] c1;
  logic signed [CMPW-1:0] i_row, j_col;
  logic [CW:0]      bound;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_NONE;
      xs_q   <= 10'd0;
      xe_q   <= 10'd1023;
      ys_q   <= 10'd0;
      ye_q   <= 10'd1023;
      crl_q  <= 10'd511;
      deg_q  <= 8'd3;
      per_q  <= 10'd32;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_MODE:      mode_q <= cfg_data_i[MODEW-1:0];
        REG_X_START:   xs_q   <= cfg_data_i[CW-1:0];
        REG_X_STOP:    xe_q   <= cfg_data_i[CW-1:0];
        REG_Y_START:   ys_q   <= cfg_data_i[CW-1:0];
        REG_Y_STOP:    ye_q   <= cfg_data_i[CW-1:0];
        REG_ROW_LIMIT: crl_q  <= cfg_data_i[CW-1:0];
        REG_DEGREE:    deg_q  <= cfg_data_i[COLW-1:0];
        REG_PI_PERIOD: per_q  <= cfg_data_i[CW-1:0];
        default:       mode_q <= mode_q;
      endcase
    end
  end

  assign w      = ucode(pc_q);
  assign run    = (state_q == ST_RUN);
  assign accept = (state_q == ST_IDLE) && start;
  assign busy   = run;

  assign deg     = (deg_q == '0) ? COLW'(1) : deg_q;
  assign striped = (mode_q == MODE_BASIN_XS) || (mode_q == MODE_BASIN_BOTHS);
  assign s       = (striped && (color_q > STRIPE)) ? STRIPE : '0;
  assign c       = color_q - s;
  assign hp2     = C1W'(deg >> 1) + C1W'(2);
  assign c1_u    = (C1W'(c) < hp2) ? (hp2 - C1W'(c)) : (hp2 + C1W'(deg) - C1W'(c));
  assign c1      = $signed(c1_u);
  assign c1s     = c1_u[COLW-1:0] + s;

  assign i_row  = $signed(CMPW'(ye_q) + CMPW'(ys_q) - CMPW'(y_q));
  assign j_col  = $signed(CMPW'(xe_q) + CMPW'(xs_q) - CMPW'(x_q));
  assign row_ok = (i_row > $signed(CMPW'(crl_q))) && (i_row < SCR_H);
  assign col_ok = !j_col[CMPW-1] && (j_col < SCR_W);

  assign bound = (mode_q == MODE_PI_BOTH) ? ((CW+1)'(xs_q) + (CW+1)'(xe_q)) >> 1
                                          : (CW+1)'(xe_q);
  assign pi_go = (x_q <= bound) && (cnt_q < MAX_CNT);

  always_comb begin
    case (w.cond)
      C_ALW:   cond_ok = 1'b1;
      C_ROW:   cond_ok = row_ok;
      C_COL:   cond_ok = col_ok;
      C_RC:    cond_ok = row_ok && col_ok;
      C_CZERO: cond_ok = (color_q == '0);
      C_NGO:   cond_ok = !pi_go;
      C_PZ:    cond_ok = (per_q == '0);
      default: cond_ok = 1'b0;
    endcase
  end

  always_comb begin
    case (w.cs)
      CS_COLOR: new_c = color_q;
      CS_C1S:   new_c = c1s;
      CS_R0:    new_c = r0_q;
      CS_R1:    new_c = r1_q;
      default:  new_c = color_q;
    endcase
  end

  assign emit_go  = run && (w.op == OP_EMIT) && cond_ok && (cnt_q < MAX_CNT);
  assign flush    = run && (w.op == OP_END) && pend_v_q;
  assign rem_done = run && (w.op == OP_REM) && rem_run_q && rem_rsp.done;

  assign rem_req.start    = run && (w.op == OP_REM) && !rem_run_q;
  assign rem_req.dividend = DIVW'(deg) + DIVW'(1) -
                            ((w.rs == RS_C1) ? DIVW'(c1) : DIVW'(c));
  assign rem_req.divisor  = deg;
  assign remap_col        = rem_rsp.rem + COLW'(1) + s;

  spwr_rem u_rem (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (rem_req),
    .rsp_o  (rem_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      pc_q      <= PC_END;
      cnt_q     <= '0;
      rem_run_q <= 1'b0;
      pend_v_q  <= 1'b0;
      valid_q   <= 1'b0;
    end else begin
      valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (start) begin
            state_q <= ST_RUN;
            pc_q    <= entry(mode_q);
            cnt_q   <= '0;
          end
        end
        ST_RUN: begin
          case (w.op)
            OP_EMIT: begin
              if (emit_go) begin
                valid_q  <= pend_v_q;
                pend_v_q <= 1'b1;
                cnt_q    <= cnt_q + CNTW'(1);
              end
              pc_q <= pc_q + PCW'(1);
            end
            OP_JMP: pc_q <= cond_ok ? w.tgt : pc_q + PCW'(1);
            OP_REM: begin
              if (!rem_run_q) begin
                rem_run_q <= 1'b1;
              end else if (rem_rsp.done) begin
                rem_run_q <= 1'b0;
                pc_q      <= pc_q + PCW'(1);
              end
            end
            OP_ADV: pc_q <= w.tgt;
            OP_END: begin
              valid_q  <= pend_v_q;
              pend_v_q <= 1'b0;
              state_q  <= ST_IDLE;
            end
            default: state_q <= ST_IDLE;
          endcase
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      x_q     <= (CW+1)'(pix_x_i);
      y_q     <= pix_y_i;
      color_q <= pix_color_i;
    end else if (run && (w.op == OP_ADV)) begin
      x_q <= x_q + (CW+1)'(per_q);
    end
    if (rem_done) begin
      if (w.rs == RS_C1) begin
        r1_q <= remap_col;
      end else begin
        r0_q <= remap_col;
      end
    end
    if (emit_go) begin
      pend_x_q <= (w.xs == XS_J) ? j_col[CW-1:0] : x_q[CW-1:0];
      pend_y_q <= (w.ys == YS_I) ? i_row[CW-1:0] : y_q;
      pend_c_q <= new_c;
    end
    if ((emit_go && pend_v_q) || flush) begin
      out_x_q <= pend_x_q;
      out_y_q <= pend_y_q;
      out_c_q <= pend_c_q;
      last_q  <= flush;
    end
  end

  assign valid_o    = valid_q;
  assign wr_x_o     = out_x_q;
  assign wr_y_o     = out_y_q;
  assign wr_color_o = out_c_q;
  assign last_o     = last_q;

  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !pend_v_q)
    else $error("write left pending while idle");

  a_cnt_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= MAX_CNT)
    else $error("write count beyond its cap");

  a_last_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && last_o) |=> !valid_o)
    else $error("write transfer directly after the final one");

  a_rem_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_run_q |-> (run && (w.op == OP_REM)))
    else $error("remainder running outside its control step");

endmodule

`default_nettype wire

/* verif/tb.sv */
// Self-checking testbench for the symmetric pixel write replicator core.
module tb;
  import spwr_pkg::*;

  localparam int SETTLE_CYCLES = 600;
  localparam int STALL_LIMIT   = 3000;

  typedef struct packed {
    logic [CW-1:0]   x;
    logic [CW-1:0]   y;
    logic [COLW-1:0] color;
  } pixel_t;

  typedef struct packed {
    logic [CW-1:0]   x;
    logic [CW-1:0]   y;
    logic [COLW-1:0] color;
    logic            last;
  } pixel_write_t;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                start       = 1'b0;
  logic                busy;
  logic [CW-1:0]       pix_x_i     = '0;
  logic [CW-1:0]       pix_y_i     = '0;
  logic [COLW-1:0]     pix_color_i = '0;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CFG_IDXW-1:0] cfg_index_i = '0;
  logic [CFG_DW-1:0]   cfg_data_i  = '0;
  logic                valid_o;
  logic [CW-1:0]       wr_x_o;
  logic [CW-1:0]       wr_y_o;
  logic [COLW-1:0]     wr_color_o;
  logic                last_o;

  logic [MODEW-1:0] cfg_mode      = MODE_NONE;
  logic [CW-1:0]    cfg_x_start   = 10'd0;
  logic [CW-1:0]    cfg_x_stop    = 10'd1023;
  logic [CW-1:0]    cfg_y_start   = 10'd0;
  logic [CW-1:0]    cfg_y_stop    = 10'd1023;
  logic [CW-1:0]    cfg_row_limit = 10'd511;
  logic [COLW-1:0]  cfg_degree    = 8'd3;
  logic [CW-1:0]    cfg_period    = 10'd32;

  pixel_t       pending_pixels[$];
  pixel_write_t write_burst[$];
  pixel_write_t expected_writes[$];
  logic         pix_taken   = 1'b0;
  bit           steady      = 1'b0;
  int           error_count = 0;
  int           stall_cycles;

  symmetric_pixel_write_replicator_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .pix_x_i     (pix_x_i),
    .pix_y_i     (pix_y_i),
    .pix_color_i (pix_color_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .valid_o     (valid_o),
    .wr_x_o      (wr_x_o),
    .wr_y_o      (wr_y_o),
    .wr_color_o  (wr_color_o),
    .last_o      (last_o)
  );

  always #6 clk_i = ~clk_i;

  function automatic void put_write(int x, int y, int c);
    pixel_write_t w;
    if (write_burst.size() < MAX_WRITES) begin
      w.x     = x[CW-1:0];
      w.y     = y[CW-1:0];
      w.color = c[COLW-1:0];
      w.last  = 1'b0;
      write_burst.push_back(w);
    end
  endfunction

  function automatic int mirror_row(int y);
    return int'(cfg_y_stop) - (y - int'(cfg_y_start));
  endfunction

  function automatic int mirror_col(int x);
    return int'(cfg_x_stop) - (x - int'(cfg_x_start));
  endfunction

  function automatic bit row_ok(int i);
    return i > int'(cfg_row_limit) && i < SCREEN_HEIGHT;
  endfunction

  function automatic bit col_ok(int j);
    return j >= 0 && j < SCREEN_WIDTH;
  endfunction

  function automatic int root_count();
    return (cfg_degree == 0) ? 1 : int'(cfg_degree);
  endfunction

  function automatic int basin_remap(int c);
    int d;
    d = root_count();
    return (d + 1 - c) % d + 1;
  endfunction

  function automatic void mirror_quad(int x, int y, int c);
    int j;
    int i;
    j = mirror_col(x);
    i = mirror_row(y);
    put_write(x, y, c);
    if (col_ok(j)) put_write(j, y, c);
    if (row_ok(i)) begin
      put_write(x, i, c);
      if (col_ok(j)) put_write(j, i, c);
    end
  endfunction

  function automatic void mirror_diag(int x, int y, int c);
    int j;
    int i;
    j = mirror_col(x);
    i = mirror_row(y);
    put_write(x, y, c);
    if (row_ok(i) && col_ok(j)) put_write(j, i, c);
  endfunction

  function automatic void basin_pair(int x, int y, int c, bit striped);
    int s;
    int i;
    s = (striped && c > STRIPE_STEP) ? STRIPE_STEP : 0;
    i = mirror_row(y);
    put_write(x, y, c);
    if (row_ok(i)) put_write(x, i, basin_remap(c - s) + s);
  endfunction

  function automatic void basin_quad(int x, int y, int color, bit striped);
    int d;
    int s;
    int c;
    int c1;
    int i;
    int j;
    d = root_count();
    if (color == 0) begin
      mirror_quad(x, y, color);
      return;
    end
    s = (striped && color > STRIPE_STEP) ? STRIPE_STEP : 0;
    c = color - s;
    c1 = (c < d / 2 + 2) ? d / 2 + 2 - c : d / 2 + d + 2 - c;
    j = mirror_col(x);
    i = mirror_row(y);
    put_write(x, y, c + s);
    if (col_ok(j)) put_write(j, y, c1 + s);
    if (row_ok(i)) begin
      put_write(x, i, s + basin_remap(c));
      if (col_ok(j)) put_write(j, i, s + basin_remap(c1));
    end
  endfunction

  function automatic void repeat_period(int x, int y, int c);
    int bound;
    int col;
    bound = (cfg_mode == MODE_PI_BOTH) ? (int'(cfg_x_start) + int'(cfg_x_stop)) / 2
                                       : int'(cfg_x_stop);
    col = x;
    while (col <= bound && write_burst.size() < MAX_WRITES) begin
      if (cfg_mode == MODE_PI) put_write(col, y, c);
      else if (cfg_mode == MODE_PI_ORIGIN) mirror_diag(col, y, c);
      else mirror_quad(col, y, c);
      if (cfg_period == 0) break;
      col += int'(cfg_period);
    end
  endfunction

  function automatic void predict_writes(int x, int y, int c);
    int j;
    int i;
    write_burst.delete();
    j = mirror_col(x);
    i = mirror_row(y);
    case (cfg_mode)
      MODE_X: begin
        put_write(x, y, c);
        if (row_ok(i)) put_write(x, i, c);
      end
      MODE_Y: begin
        put_write(x, y, c);
        if (col_ok(j)) put_write(j, y, c);
      end
      MODE_ORIGIN:      mirror_diag(x, y, c);
      MODE_BOTH:        mirror_quad(x, y, c);
      MODE_BASIN_X:     basin_pair(x, y, c, 1'b0);
      MODE_BASIN_XS:    basin_pair(x, y, c, 1'b1);
      MODE_BASIN_BOTH:  basin_quad(x, y, c, 1'b0);
      MODE_BASIN_BOTHS: basin_quad(x, y, c, 1'b1);
      MODE_PI, MODE_PI_ORIGIN, MODE_PI_BOTH: repeat_period(x, y, c);
      default: ;
    endcase
    if (write_burst.size() > 0) write_burst[write_burst.size() - 1].last = 1'b1;
    foreach (write_burst[k]) expected_writes.push_back(write_burst[k]);
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("%0t: mismatch in %s: got %0d, expected %0d", $time, what, got, want);
    error_count++;
  endtask

  always @(negedge clk_i) begin : drive_pixels
    pixel_t next_pix;
    if (!start || pix_taken) begin
      if (pending_pixels.size() != 0 && (steady || $urandom_range(0, 99) >= 26)) begin
        next_pix = pending_pixels.pop_front();
        pix_x_i     <= next_pix.x;
        pix_y_i     <= next_pix.y;
        pix_color_i <= next_pix.color;
        start       <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin : monitor_writes
    pixel_write_t want;
    pix_taken <= start && !busy;
    if (rst_ni && start && !busy) begin
      predict_writes(int'(pix_x_i), int'(pix_y_i), int'(pix_color_i));
    end
    if (rst_ni && valid_o) begin
      if (expected_writes.size() == 0) begin
        report_mismatch("write with nothing pending, column", int'(wr_x_o), -1);
      end else begin
        want = expected_writes.pop_front();
        if (wr_x_o != want.x) report_mismatch("wr_x", int'(wr_x_o), int'(want.x));
        if (wr_y_o != want.y) report_mismatch("wr_y", int'(wr_y_o), int'(want.y));
        if (wr_color_o != want.color) begin
          report_mismatch("wr_color", int'(wr_color_o), int'(want.color));
        end
        if (last_o != want.last) report_mismatch("last", int'(last_o), int'(want.last));
      end
    end
  end

  initial begin
    stall_cycles = 0;
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((start && !busy) || valid_o || (cfg_valid_i && cfg_ready_o)) stall_cycles = 0;
      else stall_cycles++;
    end
    $display("TB_ERROR");
    $finish;
  end

  task automatic write_reg(cfg_reg_e idx, logic [CFG_DW-1:0] data);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_MODE:      cfg_mode      = data[MODEW-1:0];
      REG_X_START:   cfg_x_start   = data;
      REG_X_STOP:    cfg_x_stop    = data;
      REG_Y_START:   cfg_y_start   = data;
      REG_Y_STOP:    cfg_y_stop    = data;
      REG_ROW_LIMIT: cfg_row_limit = data;
      REG_DEGREE:    cfg_degree    = data[COLW-1:0];
      REG_PI_PERIOD: cfg_period    = data;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic push_pixel(int x, int y, int c);
    pixel_t p;
    p.x     = x[CW-1:0];
    p.y     = y[CW-1:0];
    p.color = c[COLW-1:0];
    pending_pixels.push_back(p);
  endtask

  task automatic push_random_pixels(int n);
    repeat (n) begin
      push_pixel($urandom_range(0, 1) ? $urandom_range(0, 1023) : $urandom_range(0, 127),
                 $urandom_range(0, 1023),
                 $urandom_range(0, 1) ? $urandom_range(0, 255) : $urandom_range(0, 20));
    end
  endtask

  task automatic settle();
    @(posedge clk_i);
    while (pending_pixels.size() != 0 || start || expected_writes.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic run_phase(logic [CFG_DW-1:0] mode_word, logic [CFG_DW-1:0] xs,
                           logic [CFG_DW-1:0] xe, logic [CFG_DW-1:0] ys,
                           logic [CFG_DW-1:0] ye, logic [CFG_DW-1:0] lim,
                           logic [CFG_DW-1:0] deg_word, logic [CFG_DW-1:0] per,
                           int n, bit corners);
    write_reg(REG_MODE, mode_word);
    write_reg(REG_X_START, xs);
    write_reg(REG_X_STOP, xe);
    write_reg(REG_Y_START, ys);
    write_reg(REG_Y_STOP, ye);
    write_reg(REG_ROW_LIMIT, lim);
    write_reg(REG_DEGREE, deg_word);
    write_reg(REG_PI_PERIOD, per);
    if (corners) begin
      push_pixel(0, 0, 0);
      push_pixel(1023, 1023, 255);
    end
    push_random_pixels(n);
    settle();
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    push_random_pixels(5);
    settle();

    run_phase(CFG_DW'(MODE_X), 0, 1023, 0, 1023, 511, 3, 32, 25, 1'b1);
    run_phase(CFG_DW'(MODE_Y), 100, 900, 50, 950, 400, 3, 32, 25, 1'b1);
    run_phase(CFG_DW'(MODE_ORIGIN), 0, 1023, 0, 1023, 0, 3, 32, 25, 1'b1);
    run_phase(CFG_DW'(MODE_BOTH), 1023, 1023, 1023, 1023, 1023, 3, 32, 15, 1'b1);
    run_phase(CFG_DW'(MODE_BOTH), 0, 0, 0, 0, 0, 3, 32, 15, 1'b0);
    steady = 1'b1;
    run_phase(CFG_DW'(MODE_BASIN_X), 0, 1023, 0, 1023, 511, 3, 32, 30, 1'b1);
    run_phase(CFG_DW'(MODE_BASIN_XS), 200, 800, 0, 1023, 300, 255, 32, 30, 1'b1);
    steady = 1'b0;
    run_phase(CFG_DW'(MODE_BASIN_BOTH), 0, 1023, 0, 1023, 200, 0, 32, 30, 1'b1);
    run_phase(CFG_DW'(MODE_BASIN_BOTHS), 50, 700, 10, 1000, 100, 7, 32, 30, 1'b1);
    run_phase(CFG_DW'(MODE_BASIN_BOTHS), 0, 1023, 0, 1023, 0, 1, 32, 15, 1'b0);
    run_phase(CFG_DW'(MODE_PI), 0, 1023, 0, 1023, 511, 3, 32, 15, 1'b1);
    run_phase(CFG_DW'(MODE_PI_ORIGIN), 0, 1023, 0, 1023, 300, 3, 1023, 15, 1'b1);
    run_phase(CFG_DW'(MODE_PI_BOTH), 0, 127, 0, 1023, 0, 3, 1, 8, 1'b1);
    run_phase(CFG_DW'(MODE_PI), 0, 1023, 0, 1023, 511, 3, 0, 8, 1'b0);
    run_phase(10'd13, 0, 1023, 0, 1023, 0, 3, 32, 8, 1'b0);
    repeat (4) begin
      run_phase({6'($urandom), 4'($urandom_range(0, 15))},
                CFG_DW'($urandom_range(0, 1023)), CFG_DW'($urandom_range(0, 1023)),
                CFG_DW'($urandom_range(0, 1023)), CFG_DW'($urandom_range(0, 1023)),
                CFG_DW'($urandom_range(0, 1023)), 10'($urandom),
                CFG_DW'($urandom_range(32, 1023)), 20, 1'b0);
    end

    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
